// ----- design/nlle_pkg.sv -----
// nlle_pkg: characters, command and status types shared by the
// nmea lat/lon field extractor modules
// no dependencies
package nlle_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharZero   = 8'h30;

  localparam int unsigned FieldNumW = 5;  // width of the field number registers
  localparam int unsigned CmpW      = 6;  // common width for field number compares

  localparam logic [1:0] PartLatDeg = 2'd0;
  localparam logic [1:0] PartLonDeg = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic rd;      // read both text stores at the emit index
    logic ld;      // load the output register and advance the emit index
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic recording;  // inside a sentence
    logic rx_eol;     // incoming byte is cr or lf
    logic out_free;   // output register can take a beat this cycle
    logic seq_done;   // emit index sits on the final character
  } dp_status_t;

endpackage

// ----- design/nlle_if.sv -----
// nlle_in_if / nlle_out_if: valid/ready channels for received bytes and
// extracted characters
// no dependencies
interface nlle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nlle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] part;
  logic       last;

  modport source (output valid, output out_char, output part, output last, input ready);
  modport sink   (input valid, input out_char, input part, input last, output ready);
endinterface

// ----- design/nlle_ctrl.sv -----
// nlle_ctrl: sequencer for byte intake and character emission
// depends on nlle_pkg
module nlle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nlle_pkg::dp_status_t status_i,
  output nlle_pkg::dp_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.recording && status_i.rx_eol) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.ld = 1'b1;
          state_d  = status_i.seq_done ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/nlle_dp.sv -----
// nlle_dp: sentence counters, latitude/longitude text stores and the
// output register
// depends on nlle_pkg
module nlle_dp #(
  parameter int unsigned FIELD_LEN      = 20,
  parameter int unsigned FIELD_LIMIT    = 20,
  parameter int unsigned LINE_LEN       = 100,
  parameter int unsigned LAT_DEG_DIGITS = 2,
  parameter int unsigned LON_DEG_DIGITS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nlle_pkg::dp_cmd_t                 cmd_i,
  output nlle_pkg::dp_status_t              status_o,
  input  logic [7:0]                        rx_byte_i,
  input  logic [nlle_pkg::FieldNumW-1:0]    lat_num_i,
  input  logic [nlle_pkg::FieldNumW-1:0]    lon_num_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [7:0]                        out_char_o,
  output logic [1:0]                        out_part_o,
  output logic                              out_last_o
);

  localparam int unsigned TextCap = FIELD_LEN - 1;
  localparam int unsigned AW      = $clog2(TextCap);
  localparam int unsigned CW      = $clog2(FIELD_LEN);
  localparam int unsigned FW      = $clog2(FIELD_LIMIT + 1);
  localparam int unsigned LW      = $clog2(LINE_LEN);

  logic          recording_q, recording_d;
  logic [LW-1:0] line_cnt_q, line_cnt_d;
  logic [FW-1:0] field_cnt_q, field_cnt_d;
  logic [CW-1:0] cif_q, cif_d;
  logic [CW-1:0] lat_len_q, lat_len_d;
  logic [CW-1:0] lon_len_q, lon_len_d;
  logic          sel_q, sel_d;        // 0 latitude, 1 longitude
  logic [CW-1:0] idx_q, idx_d;

  logic [7:0] lat_mem [TextCap];
  logic [7:0] lon_mem [TextCap];
  logic [7:0] lat_rd_q, lon_rd_q;

  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic [1:0]    out_part_q;
  logic          out_last_q;

  logic          is_dollar, is_eol, is_comma;
  logic          lat_wr, lon_wr;
  logic [CW-1:0] wr_addr;
  logic          take;
  logic          lat_hit, lon_hit;
  logic [CW-1:0] cur_len, last_idx;
  logic          idx_last;
  logic          deg_char;
  logic [7:0]    emit_char;

  function automatic logic [nlle_pkg::CmpW-1:0] CmpCast(input logic [FW-1:0] v);
    CmpCast = nlle_pkg::CmpW'(v);
  endfunction

  function automatic logic [nlle_pkg::CmpW-1:0] CmpCastN(
    input logic [nlle_pkg::FieldNumW-1:0] v
  );
    CmpCastN = nlle_pkg::CmpW'(v);
  endfunction

  function automatic logic [1:0] PartCode(input logic sel, input logic deg);
    PartCode = (sel ? nlle_pkg::PartLonDeg : nlle_pkg::PartLatDeg) + {1'b0, ~deg};
  endfunction

  assign is_dollar = (rx_byte_i == nlle_pkg::CharDollar);
  assign is_eol    = (rx_byte_i == nlle_pkg::CharCr) || (rx_byte_i == nlle_pkg::CharLf);
  assign is_comma  = (rx_byte_i == nlle_pkg::CharComma);

  assign lat_hit = (CmpCast(field_cnt_q) == CmpCastN(lat_num_i));
  assign lon_hit = (CmpCast(field_cnt_q) == CmpCastN(lon_num_i));

  // emission bookkeeping
  assign cur_len  = sel_q ? lon_len_q : lat_len_q;
  assign last_idx = (cur_len == '0) ? '0 : cur_len - CW'(1);
  assign idx_last = (idx_q == last_idx);
  assign deg_char = sel_q ? ({{(32-CW){1'b0}}, idx_q} < 32'(LON_DEG_DIGITS))
                          : ({{(32-CW){1'b0}}, idx_q} < 32'(LAT_DEG_DIGITS));
  assign emit_char = sel_q ? ((lon_len_q == '0) ? nlle_pkg::CharZero : lon_rd_q)
                           : ((lat_len_q == '0) ? nlle_pkg::CharZero : lat_rd_q);

  always_comb begin
    recording_d = recording_q;
    line_cnt_d  = line_cnt_q;
    field_cnt_d = field_cnt_q;
    cif_d       = cif_q;
    lat_len_d   = lat_len_q;
    lon_len_d   = lon_len_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    lat_wr      = 1'b0;
    lon_wr      = 1'b0;
    wr_addr     = cif_q;
    take        = 1'b0;

    if (cmd_i.accept) begin
      priority if (is_dollar) begin
        // '$' restarts and is itself the first character of field 0
        recording_d = 1'b1;
        line_cnt_d  = LW'(1);
        field_cnt_d = '0;
        cif_d       = CW'(1);
        wr_addr     = '0;
        lat_wr      = (lat_num_i == '0);
        lon_wr      = (lon_num_i == '0);
        lat_len_d   = (lat_num_i == '0) ? CW'(1) : '0;
        lon_len_d   = (lon_num_i == '0) ? CW'(1) : '0;
      end else if (!recording_q) begin
        recording_d = recording_q;
      end else if (is_eol) begin
        recording_d = 1'b0;
        line_cnt_d  = '0;
        sel_d       = 1'b0;
        idx_d       = '0;
      end else begin
        if (line_cnt_q < LW'(LINE_LEN - 1)) begin
          line_cnt_d = line_cnt_q + LW'(1);
          take       = 1'b1;
        end
      end
    end

    if (take && (field_cnt_q < FW'(FIELD_LIMIT))) begin
      if (is_comma) begin
        field_cnt_d = field_cnt_q + FW'(1);
        cif_d       = '0;
      end else if (cif_q < CW'(TextCap)) begin
        lat_wr = lat_hit;
        lon_wr = lon_hit;
        if (lat_hit) lat_len_d = cif_q + CW'(1);
        if (lon_hit) lon_len_d = cif_q + CW'(1);
        cif_d = cif_q + CW'(1);
      end
    end

    if (cmd_i.ld) begin
      if (idx_last) begin
        sel_d = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q <= 1'b0;
      line_cnt_q  <= '0;
      field_cnt_q <= '0;
      cif_q       <= '0;
      lat_len_q   <= '0;
      lon_len_q   <= '0;
      sel_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      recording_q <= recording_d;
      line_cnt_q  <= line_cnt_d;
      field_cnt_q <= field_cnt_d;
      cif_q       <= cif_d;
      lat_len_q   <= lat_len_d;
      lon_len_q   <= lon_len_d;
      sel_q       <= sel_d;
      idx_q       <= idx_d;
      if (cmd_i.ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // text stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (lat_wr) lat_mem[wr_addr[AW-1:0]] <= rx_byte_i;
    if (lon_wr) lon_mem[wr_addr[AW-1:0]] <= rx_byte_i;
    if (cmd_i.rd) begin
      lat_rd_q <= lat_mem[idx_q[AW-1:0]];
      lon_rd_q <= lon_mem[idx_q[AW-1:0]];
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      out_char_q <= emit_char;
      out_part_q <= PartCode(sel_q, deg_char);
      out_last_q <= sel_q & idx_last;
    end
  end

  assign status_o.recording = recording_q;
  assign status_o.rx_eol    = is_eol;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.seq_done  = sel_q & idx_last;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_part_o  = out_part_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- design/nmea_lat_lon_field_extractor.sv -----
// nmea_lat_lon_field_extractor: top level, apb field number registers,
// controller and datapath
// depends on nlle_pkg, nlle_in_if, nlle_out_if, nlle_ctrl, nlle_dp
//
//  channel  dir  beat payload                     handshake
//  rx_i     in   rx_byte[7:0]                     valid/ready
//  res_o    out  out_char[7:0] part[1:0] last     valid/ready
//  apb      in   lat_field_number @0x0, lon_field_number @0x4 (5 bits each)
//
// an ordinary byte is taken and the block stays ready for the next one
// a cr/lf inside a sentence starts emission: each character takes a store
// read, then an output register load, for up to 2*(FIELD_LEN-1) characters,
// and no further byte is taken until the final character is loaded
// a stalled result holds the emission in place; the output register lets the
// next byte be taken while the final character still waits
// reset clears control state only; text stores are not cleared
module nmea_lat_lon_field_extractor #(
  parameter int unsigned FIELD_LEN      = 20,
  parameter int unsigned FIELD_LIMIT    = 20,
  parameter int unsigned LINE_LEN       = 100,
  parameter int unsigned LAT_DEG_DIGITS = 2,
  parameter int unsigned LON_DEG_DIGITS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nlle_in_if.sink     rx_i,
  nlle_out_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegLat = 1'b0;
  localparam logic RegLon = 1'b1;

  logic [nlle_pkg::FieldNumW-1:0] lat_num_q, lon_num_q;
  logic                           cfg_wr;
  nlle_pkg::dp_cmd_t              cmd;
  nlle_pkg::dp_status_t           status;

  // configuration registers, written in the apb access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_num_q <= nlle_pkg::FieldNumW'(2);
      lon_num_q <= nlle_pkg::FieldNumW'(4);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegLat:  lat_num_q <= pwdata[nlle_pkg::FieldNumW-1:0];
        RegLon:  lon_num_q <= pwdata[nlle_pkg::FieldNumW-1:0];
        default: lat_num_q <= lat_num_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegLat:  prdata = 32'(lat_num_q);
      RegLon:  prdata = 32'(lon_num_q);
      default: prdata = '0;
    endcase
  end

  // sequencer: owns input ready and emission pacing
  nlle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, text stores and output register
  nlle_dp #(
    .FIELD_LEN      (FIELD_LEN),
    .FIELD_LIMIT    (FIELD_LIMIT),
    .LINE_LEN       (LINE_LEN),
    .LAT_DEG_DIGITS (LAT_DEG_DIGITS),
    .LON_DEG_DIGITS (LON_DEG_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .rx_byte_i   (rx_i.rx_byte),
    .lat_num_i   (lat_num_q),
    .lon_num_i   (lon_num_q),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_char_o  (res_o.out_char),
    .out_part_o  (res_o.part),
    .out_last_o  (res_o.last)
  );

endmodule

// ----- bench/nmea_lat_lon_field_extractor_tb.sv -----
`timescale 1ns / 1ps
// nmea_lat_lon_field_extractor_tb: self-checking bench for the nmea lat/lon field extractor,
// a behavioural copy of the extractor predicts every emitted coordinate beat
// depends on nlle_pkg, nlle_in_if, nlle_out_if and the extractor rtl
module nmea_lat_lon_field_extractor_tb;

  // block sizes, kept equal to the defaults of the rtl
  localparam int unsigned FieldLen     = 20;
  localparam int unsigned FieldLimit   = 20;
  localparam int unsigned LineLen      = 100;
  localparam int unsigned LatDegDigits = 2;
  localparam int unsigned LonDegDigits = 3;
  localparam int unsigned TextCap      = FieldLen - 1;

  // apb register map
  localparam logic [2:0] AddrLatField = 3'd0;
  localparam logic [2:0] AddrLonField = 3'd4;

  localparam int unsigned RandomItems    = 30;
  localparam int unsigned DrainCycles    = 100;   // room for the emission of 38 chars
  localparam int unsigned WatchdogCycles = 2000;  // longest stall plus drain, several times over

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] part;
    logic       last;
  } coord_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nlle_in_if  rx_if ();
  nlle_out_if res_if ();

  nmea_lat_lon_field_extractor #(
    .FIELD_LEN     (FieldLen),
    .FIELD_LIMIT   (FieldLimit),
    .LINE_LEN      (LineLen),
    .LAT_DEG_DIGITS(LatDegDigits),
    .LON_DEG_DIGITS(LonDegDigits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // extractor state as the bench sees it
  // ---------------------------------------------------------------------------
  logic       in_sentence;
  logic [6:0] line_bytes;            // bytes taken in this sentence, '$' included
  logic [4:0] field_idx;             // saturates at the field limit
  logic [4:0] field_pos;             // chars kept in the current field
  logic [7:0] lat_txt [TextCap];
  logic [7:0] lon_txt [TextCap];
  logic [4:0] lat_len;
  logic [4:0] lon_len;
  logic [4:0] lat_sel;               // field number registers
  logic [4:0] lon_sel;

  coord_beat_t coord_q[$];           // coordinate beats still to come out

  int unsigned bytes_sent;
  int unsigned sentences_done;
  int unsigned beats_checked;
  int unsigned reg_writes;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          calm;                 // no gaps and no new stalls while set
  coord_beat_t want;

  function automatic void clear_extractor();
    in_sentence = 1'b0;
    line_bytes  = '0;
    field_idx   = '0;
    field_pos   = '0;
    lat_len     = '0;
    lon_len     = '0;
    lat_sel     = 5'd2;
    lon_sel     = 5'd4;
    for (int i = 0; i < TextCap; i++) begin
      lat_txt[i] = '0;
      lon_txt[i] = '0;
    end
  endfunction

  // one byte of a sentence that fits in the line
  function automatic void keep_char(input logic [7:0] c);
    // past the last field nothing more is kept, commas included
    if (field_idx >= FieldLimit) return;
    if (c == nlle_pkg::CharComma) begin
      field_idx = field_idx + 5'd1;
      field_pos = '0;
      return;
    end
    if (field_pos >= TextCap) return;
    // both selectors may point at the same field
    if (field_idx == lat_sel) begin
      lat_txt[field_pos] = c;
      lat_len            = field_pos + 5'd1;
    end
    if (field_idx == lon_sel) begin
      lon_txt[field_pos] = c;
      lon_len            = field_pos + 5'd1;
    end
    field_pos = field_pos + 5'd1;
  endfunction

  // degrees first, the rest as minutes; an empty field reads as "0"
  function automatic void queue_coord(input logic [7:0] txt [TextCap], input logic [4:0] len,
                                      input int unsigned deg_digits, input logic [1:0] deg_part);
    coord_beat_t b;
    b.last = 1'b0;
    if (len == 0) begin
      b.ch   = nlle_pkg::CharZero;
      b.part = deg_part;
      coord_q.push_back(b);
      return;
    end
    for (int i = 0; i < len; i++) begin
      b.ch   = txt[i];
      b.part = (i < deg_digits) ? deg_part : deg_part + 2'd1;
      coord_q.push_back(b);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    // '$' always (re)starts, and is itself the first char of field 0
    if (c == nlle_pkg::CharDollar) begin
      in_sentence = 1'b1;
      line_bytes  = 7'd1;
      field_idx   = '0;
      field_pos   = '0;
      lat_len     = '0;
      lon_len     = '0;
      keep_char(c);
      return;
    end
    if (!in_sentence) return;
    if (c == nlle_pkg::CharCr || c == nlle_pkg::CharLf) begin
      in_sentence = 1'b0;
      line_bytes  = '0;
      queue_coord(lat_txt, lat_len, LatDegDigits, nlle_pkg::PartLatDeg);
      queue_coord(lon_txt, lon_len, LonDegDigits, nlle_pkg::PartLonDeg);
      coord_q[coord_q.size() - 1].last = 1'b1;
      sentences_done++;
      return;
    end
    // line full: later bytes are dropped but cr/lf still ends the sentence
    if (line_bytes < LineLen - 1) begin
      line_bytes = line_bytes + 7'd1;
      keep_char(c);
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    rx_if.rx_byte = b;
    rx_if.valid   = 1'b1;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk_i);
    rx_if.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrLatField) lat_sel = data[4:0];
    else lon_sel = data[4:0];
    reg_writes++;
    @(negedge clk_i);
    // read data follows the address, so the new value shows at once
    if (prdata !== 32'(data[4:0])) begin
      $display("%0t: prdata expected %h got %h", $time, 32'(data[4:0]), prdata);
      err_cnt++;
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drain();
    while (coord_q.size() != 0) @(negedge clk_i);
  endtask

  // all beats out, then room for a byte still being taken
  task automatic wait_idle();
    wait_drain();
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // upper bits carry junk now and then, only the low five count
  task automatic set_fields(input logic [4:0] lat, input logic [4:0] lon);
    logic [26:0] junk;
    wait_idle();
    junk = ($urandom_range(0, 3) == 0) ? 27'($urandom()) : '0;
    apb_write(AddrLatField, {junk, lat});
    apb_write(AddrLonField, {junk, lon});
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return nlle_pkg::CharZero + 8'(r);
    if (r == 10) return ".";
    // any other byte, separators and line ends excepted
    do c = 8'($urandom());
    while (c == nlle_pkg::CharDollar || c == nlle_pkg::CharComma ||
           c == nlle_pkg::CharCr || c == nlle_pkg::CharLf);
    return c;
  endfunction

  function automatic logic [4:0] pick_field_number();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 5'd0;
      1: return 5'd19;
      2: return 5'd20;
      3: return 5'd31;
      4, 5: return 5'($urandom_range(0, 31));
      default: return 5'($urandom_range(0, 6));
    endcase
  endfunction

  // well-formed sentences mostly, some left open, some plain noise
  task automatic send_random_sentence();
    int unsigned kind;
    int unsigned n_fields;
    int unsigned flen;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom()));
      return;
    end
    send_byte(nlle_pkg::CharDollar);
    n_fields = (kind < 85) ? $urandom_range(3, 8) : $urandom_range(0, 24);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) send_byte(nlle_pkg::CharComma);
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 26) : $urandom_range(0, 10);
      repeat (flen) send_byte(field_char());
    end
    if (kind < 92) begin
      case ($urandom_range(0, 2))
        0: send_byte(nlle_pkg::CharCr);
        1: send_byte(nlle_pkg::CharLf);
        default: begin
          send_byte(nlle_pkg::CharCr);
          send_byte(nlle_pkg::CharLf);   // lf after cr falls outside a sentence
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_bytes_outside_sentence();
    send_text("ab,9");
    send_byte(nlle_pkg::CharCr);
    send_byte(nlle_pkg::CharLf);
  endtask

  task automatic test_plain_fix();
    send_text("$GPGGA,123519,4807.038,N,01131.000,E");
    send_byte(nlle_pkg::CharCr);
    send_byte(nlle_pkg::CharLf);
  endtask

  // one-char and empty coordinate fields, and fields never reached
  task automatic test_short_and_empty();
    send_text("$P,,4,,7");
    send_byte(nlle_pkg::CharLf);
    send_text("$P,x,");
    send_byte(nlle_pkg::CharCr);
  endtask

  // restart inside a sentence, zero byte and high bytes as plain chars
  task automatic test_restart_and_odd_bytes();
    send_text("$A,9,$B,Q,");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("1,z,");
    send_byte(8'h7F);
    send_byte(nlle_pkg::CharLf);
  endtask

  // both coordinate fields over the store size: the most beats for one line end
  task automatic test_long_fields();
    send_text("$L,x,");
    for (int i = 0; i < 24; i++) send_byte(nlle_pkg::CharZero + 8'(i % 10));
    send_text(",y,");
    for (int i = 0; i < 22; i++) send_byte(nlle_pkg::CharZero + 8'(9 - i % 10));
    send_byte(nlle_pkg::CharCr);
  endtask

  // bytes past the line capacity must not reach the longitude field
  task automatic test_line_full();
    send_text("$,,12,");
    repeat (100) send_byte("x");
    send_text(",77");
    send_byte(nlle_pkg::CharCr);
  endtask

  task automatic test_field_numbers();
    // last field in range, and the first one out of range
    set_fields(5'd19, 5'd20);
    send_byte(nlle_pkg::CharDollar);
    for (int f = 1; f < 23; f++) begin
      send_byte(nlle_pkg::CharComma);
      send_byte(nlle_pkg::CharZero + 8'(f % 10));
    end
    send_byte(nlle_pkg::CharCr);
    // field 0 holds the '$', top register value never matches
    set_fields(5'd0, 5'd31);
    send_text("$AB,1");
    send_byte(nlle_pkg::CharCr);
    // both coordinates from one field
    set_fields(5'd3, 5'd3);
    send_text("$a,b,c,4455.5");
    send_byte(nlle_pkg::CharLf);
  endtask

  // a new field number applies to later bytes only
  task automatic test_write_mid_sentence();
    set_fields(5'd2, 5'd4);
    send_text("$A,");
    wait_idle();
    apb_write(AddrLatField, 32'd1);
    apb_write(AddrLonField, 32'd0);
    send_text("12345,X");
    send_byte(nlle_pkg::CharCr);
    set_fields(5'd2, 5'd4);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    send_text("$GPRMC,081836,A,3751.65,S,14507.36,E");
    send_byte(nlle_pkg::CharCr);
    send_text("$GPGLL,,,5133.81,N");
    send_byte(nlle_pkg::CharLf);
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    logic [4:0]  lat;
    start = bytes_sent;
    while (bytes_sent - start < RandomItems) begin
      lat = pick_field_number();
      set_fields(lat, ($urandom_range(0, 7) == 0) ? lat : pick_field_number());
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (bytes_sent - start >= RandomItems) break;
        send_random_sentence();
        // hold the sender until the block has emptied
        if ($urandom_range(0, 9) == 0) wait_drain();
      end
      // close any open sentence before the next register change
      if (in_sentence) send_byte(nlle_pkg::CharCr);
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure, checking and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        stall_left   = pick_gap();
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (coord_q.size() == 0) begin
        $display("%0t: beat with nothing expected: char %h part %0d last %b", $time,
                 res_if.out_char, res_if.part, res_if.last);
        err_cnt++;
      end else begin
        want = coord_q.pop_front();
        beats_checked++;
        if (res_if.out_char !== want.ch) begin
          $display("%0t: out_char expected %h got %h", $time, want.ch, res_if.out_char);
          err_cnt++;
        end
        if (res_if.part !== want.part) begin
          $display("%0t: part expected %0d got %0d", $time, want.part, res_if.part);
          err_cnt++;
        end
        if (res_if.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, res_if.last);
          err_cnt++;
        end
      end
    end
  end

  // any beat or register access counts as progress
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogCycles) begin
      $display("%0t: no progress for %0d cycles, %0d beats outstanding", $time,
               idle_cycles, coord_q.size());
      $display("nmea_lat_lon_field_extractor_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    bytes_sent     = 0;
    sentences_done = 0;
    beats_checked  = 0;
    reg_writes     = 0;
    err_cnt        = 0;
    idle_cycles    = 0;
    clear_extractor();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_bytes_outside_sentence();
    test_plain_fix();
    test_short_and_empty();
    test_restart_and_odd_bytes();
    test_long_fields();
    test_line_full();
    test_field_numbers();
    test_write_mid_sentence();
    test_back_to_back();
    test_random_traffic();

    wait_drain();
    repeat (DrainCycles) @(negedge clk_i);
    $display("run: %0d bytes sent, %0d sentences closed, %0d chars checked, %0d reg writes",
             bytes_sent, sentences_done, beats_checked, reg_writes);
    $display("run: field numbers 0 to 31, long, short, empty and clipped fields, restarts");
    if (err_cnt == 0 && coord_q.size() == 0) begin
      $display("nmea_lat_lon_field_extractor_tb: clean");
    end else begin
      $display("nmea_lat_lon_field_extractor_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/nlle_pkg.sv
design/nlle_if.sv
design/nlle_ctrl.sv
design/nlle_dp.sv
design/nmea_lat_lon_field_extractor.sv
bench/nmea_lat_lon_field_extractor_tb.sv
